// ===== hw/rtl/ggna_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggna_pkg: shared types and constants
// Defaults, opcodes and cell control word for the nearest assignment block.
// ----------------------------------------------------------------------------
package ggna_pkg;

   localparam int MAX_TRACKS_DEF     = 32;
   localparam int MAX_DETECTIONS_DEF = 32;
   localparam int COORD_BITS_DEF     = 16;
   localparam int MAX_RESULTS        = 32;
   localparam int POS_W              = 16;
   localparam int GATE_W             = 34;
   localparam int IDX_OUT_W          = 5;
   localparam logic [GATE_W-1:0] GATE_RESET = 34'd1000000;

   localparam logic [1:0] OP_LOAD_TRACK = 2'd0;
   localparam logic [1:0] OP_LOAD_DET   = 2'd1;
   localparam logic [1:0] OP_SOLVE      = 2'd2;

   // broadcast controls from the sequencer to every cell
   typedef struct packed {
      logic load;         // store the request position in the selected cell
      logic take;         // mark the selected cell's track as assigned
      logic frame_clear;  // drop all assignments
      logic round_clear;  // forget the per-track best of the last round
      logic cmp;          // squared distance at the compare stage is valid
      logic reduce;       // shift the running minimum one cell along
   } cell_ctl_type;

endpackage

// ===== hw/rtl/ggna_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggna_ram: generic single write, single read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ggna_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 32
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [$clog2(DEPTH>1?DEPTH:2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                  wr_data,
   input  logic [$clog2(DEPTH>1?DEPTH:2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                  rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hw/rtl/ggna_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggna_cell: one track cell
// Holds one track, tracks its nearest free detection, and passes the running
// minimum to the next cell.
// ----------------------------------------------------------------------------
module ggna_cell
   import ggna_pkg::*;
#(
   parameter int IDX  = 0,
   parameter int CW   = 16,
   parameter int TI_W = 5,
   parameter int DI_W = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cell_ctl_type         ctl,
   input  logic                 sel,
   input  logic                 present,
   input  logic [3*CW-1:0]      load_pos,
   input  logic [3*CW-1:0]      det_pos,
   input  logic [DI_W-1:0]      det_idx,
   input  logic                 prev_found,
   input  logic [2*CW+3:0]      prev_dist,
   input  logic [TI_W-1:0]      prev_t,
   input  logic [DI_W-1:0]      prev_d,
   output logic                 carry_found,
   output logic [2*CW+3:0]      carry_dist,
   output logic [TI_W-1:0]      carry_t,
   output logic [DI_W-1:0]      carry_d
);
   localparam int SQ_W   = 2*(CW+1);
   localparam int DIST_W = SQ_W+2;

   logic [3*CW-1:0]       pos_ff;
   logic                  taken_ff;
   logic signed [CW:0]    diff_ff [3];
   logic [SQ_W-1:0]       sq_ff [3];
   logic                  bfound_ff;
   logic [DIST_W-1:0]     bdist_ff;
   logic [DI_W-1:0]       bidx_ff;
   logic                  cfound_ff;
   logic [DIST_W-1:0]     cdist_ff;
   logic [TI_W-1:0]       ct_ff;
   logic [DI_W-1:0]       cd_ff;
   logic signed [CW:0]    diff_in [3];
   logic signed [SQ_W-1:0] sq_in [3];
   logic [DIST_W-1:0]     sum;
   logic                  own_wins;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         diff_in[k] = $signed({det_pos[k*CW+CW-1], det_pos[k*CW +: CW]})
                    - $signed({pos_ff[k*CW+CW-1], pos_ff[k*CW +: CW]});
         sq_in[k]   = diff_ff[k] * diff_ff[k];
      end
   end

   assign sum = DIST_W'(sq_ff[0]) + DIST_W'(sq_ff[1]) + DIST_W'(sq_ff[2]);
   // strict compare: on a tie the lower track (upstream) keeps the lead
   assign own_wins = present && !taken_ff && bfound_ff
                     && (!prev_found || bdist_ff < prev_dist);

   always_ff @(posedge clock) begin
      if (reset) begin
         taken_ff  <= 1'b0;
         bfound_ff <= 1'b0;
      end else begin
         if (ctl.frame_clear) begin
            taken_ff <= 1'b0;
         end else if (ctl.take && sel) begin
            taken_ff <= 1'b1;
         end
         if (ctl.round_clear) begin
            bfound_ff <= 1'b0;
         end else if (ctl.cmp && (!bfound_ff || sum < bdist_ff)) begin
            bfound_ff <= 1'b1;
         end
      end
      if (ctl.load && sel) begin
         pos_ff <= load_pos;
      end
      for (int k = 0; k < 3; k++) begin
         diff_ff[k] <= diff_in[k];
         sq_ff[k]   <= $unsigned(sq_in[k]);
      end
      if (ctl.cmp && (!bfound_ff || sum < bdist_ff)) begin
         bdist_ff <= sum;
         bidx_ff  <= det_idx;
      end
      if (ctl.reduce) begin
         cfound_ff <= own_wins || prev_found;
         cdist_ff  <= own_wins ? bdist_ff : prev_dist;
         ct_ff     <= own_wins ? TI_W'(IDX) : prev_t;
         cd_ff     <= own_wins ? bidx_ff : prev_d;
      end
   end

   assign carry_found = cfound_ff;
   assign carry_dist  = cdist_ff;
   assign carry_t     = ct_ff;
   assign carry_d     = cd_ff;
endmodule

// ===== hw/rtl/greedy_gated_nearest_assignment.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_gated_nearest_assignment: greedy gated nearest pair assignment
// Tracks live in a row of cells, detections in a RAM. A solve repeatedly
// finds the closest free pair and accepts it while it lies within the gate.
// ----------------------------------------------------------------------------
// channel   ports                          handshake
// request   req_op, req_pos_x/y/z          start high while busy low
// response  rsp_matched/track_index/...    rsp_valid, one cycle, no stall
// csr       csr_wr_data                    csr_wr_en, one cycle
//
// Load words never raise busy. Each solve round sets up, sweeps the D loaded
// detections (MAX_DETECTIONS at most) through the compare pipe, drains its
// three words and makes the empty check, then shifts the reduction along the
// T = MAX_TRACKS cells of the row. There is one round per accepted pair, plus
// a failing one unless MAX_RESULTS pairs were found, then a finish state.
// The detection sweep reads the RAM once a cycle; the reduction walks the row.
// Reset is synchronous and empties the frame; the receiver cannot stall.
// ----------------------------------------------------------------------------
module greedy_gated_nearest_assignment
   import ggna_pkg::*;
#(
   parameter int MAX_TRACKS     = MAX_TRACKS_DEF,
   parameter int MAX_DETECTIONS = MAX_DETECTIONS_DEF,
   parameter int COORD_BITS     = COORD_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [1:0]              req_op,
   input  logic signed [POS_W-1:0] req_pos_x,
   input  logic signed [POS_W-1:0] req_pos_y,
   input  logic signed [POS_W-1:0] req_pos_z,
   output logic                    rsp_valid,
   output logic                    rsp_matched,
   output logic [IDX_OUT_W-1:0]    rsp_track_index,
   output logic [IDX_OUT_W-1:0]    rsp_detection_index,
   output logic                    rsp_last,
   input  logic                    csr_wr_en,
   input  logic [GATE_W-1:0]       csr_wr_data
);
   localparam int CW     = COORD_BITS;
   localparam int DIST_W = 2*(CW+1)+2;
   localparam int EXT_W  = (CW > POS_W) ? CW : POS_W;
   localparam int TI_W   = $clog2(MAX_TRACKS > 1 ? MAX_TRACKS : 2);
   localparam int DI_W   = $clog2(MAX_DETECTIONS > 1 ? MAX_DETECTIONS : 2);
   localparam int TC_W   = $clog2(MAX_TRACKS+1);
   localparam int DC_W   = $clog2(MAX_DETECTIONS+1);
   localparam int RC_W   = $clog2(MAX_RESULTS+1);
   localparam int CMP_W  = (DIST_W > GATE_W) ? DIST_W : GATE_W;

   typedef enum logic [2:0] {
      ST_IDLE, ST_ROUND, ST_SWEEP, ST_REDUCE, ST_DECIDE, ST_FINISH
   } state_type;

   state_type             state_ff;
   logic [GATE_W-1:0]     gate_ff;
   logic [TC_W-1:0]       tcount_ff;
   logic [DC_W-1:0]       dcount_ff;
   logic [MAX_DETECTIONS-1:0] dtaken_ff;
   logic [DC_W-1:0]       issue_ff;
   logic                  v1_ff, v2_ff, v3_ff;
   logic [DI_W-1:0]       d1_ff, d2_ff, d3_ff;
   logic [TI_W-1:0]       red_ff;
   logic [RC_W-1:0]       nres_ff;
   logic                  pend_ff;
   logic [TI_W-1:0]       pend_t_ff;
   logic [DI_W-1:0]       pend_d_ff;
   logic                  rsp_valid_ff, rsp_matched_ff, rsp_last_ff;
   logic [IDX_OUT_W-1:0]  rsp_t_ff, rsp_d_ff;

   cell_ctl_type          ctl;
   logic [3*CW-1:0]       load_pos;
   logic [EXT_W-1:0]      ext_x, ext_y, ext_z;
   logic [3*CW-1:0]       det_pos;
   logic                  accept;
   logic                  issue_go;
   logic                  win;
   logic [DI_W-1:0]       issue_addr;

   // chain wiring: element i feeds cell i, element MAX_TRACKS is the row end
   logic                  ch_found [MAX_TRACKS+1];
   logic [DIST_W-1:0]     ch_dist  [MAX_TRACKS+1];
   logic [TI_W-1:0]       ch_t     [MAX_TRACKS+1];
   logic [DI_W-1:0]       ch_d     [MAX_TRACKS+1];

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   // low COORD_BITS of each coordinate, sign taken from that width
   assign ext_x    = EXT_W'($unsigned(req_pos_x));
   assign ext_y    = EXT_W'($unsigned(req_pos_y));
   assign ext_z    = EXT_W'($unsigned(req_pos_z));
   assign load_pos = {ext_z[CW-1:0], ext_y[CW-1:0], ext_x[CW-1:0]};

   assign issue_addr = issue_ff[DI_W-1:0];
   assign issue_go   = (state_ff == ST_SWEEP) && (issue_ff < dcount_ff);

   // winner at the row end, gated against the squared gate
   assign win = ch_found[MAX_TRACKS]
                && (CMP_W'(ch_dist[MAX_TRACKS]) <= CMP_W'(gate_ff));

   always_comb begin
      ctl.load        = accept && (req_op == OP_LOAD_TRACK)
                        && (tcount_ff < TC_W'(MAX_TRACKS));
      ctl.take        = (state_ff == ST_DECIDE) && win;
      ctl.frame_clear = (state_ff == ST_FINISH);
      ctl.round_clear = (state_ff == ST_ROUND);
      ctl.cmp         = v3_ff;
      ctl.reduce      = (state_ff == ST_REDUCE);
   end

   ggna_ram #(
      .WIDTH (3*CW),
      .DEPTH (MAX_DETECTIONS)
   ) u_det_ram (
      .clock   (clock),
      .wr_en   (accept && (req_op == OP_LOAD_DET)
                && (dcount_ff < DC_W'(MAX_DETECTIONS))),
      .wr_addr (dcount_ff[DI_W-1:0]),
      .wr_data (load_pos),
      .rd_addr (issue_addr),
      .rd_data (det_pos)
   );

   assign ch_found[0] = 1'b0;
   assign ch_dist[0]  = '0;
   assign ch_t[0]     = '0;
   assign ch_d[0]     = '0;

   for (genvar i = 0; i < MAX_TRACKS; i++) begin : g_cell
      logic sel;
      // load target is the next free cell; take target is the winning track
      assign sel = (state_ff == ST_DECIDE) ? (ch_t[MAX_TRACKS] == TI_W'(i))
                                           : (tcount_ff == TC_W'(i));
      ggna_cell #(
         .IDX  (i),
         .CW   (CW),
         .TI_W (TI_W),
         .DI_W (DI_W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .sel         (sel),
         .present     (TC_W'(i) < tcount_ff),
         .load_pos    (load_pos),
         .det_pos     (det_pos),
         .det_idx     (d3_ff),
         .prev_found  (ch_found[i]),
         .prev_dist   (ch_dist[i]),
         .prev_t      (ch_t[i]),
         .prev_d      (ch_d[i]),
         .carry_found (ch_found[i+1]),
         .carry_dist  (ch_dist[i+1]),
         .carry_t     (ch_t[i+1]),
         .carry_d     (ch_d[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gate_ff      <= GATE_RESET;
         tcount_ff    <= '0;
         dcount_ff    <= '0;
         dtaken_ff    <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            gate_ff <= csr_wr_data;
         end
         // detection pipeline: RAM read, difference, square, compare
         v1_ff <= issue_go && !dtaken_ff[issue_addr];
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  unique case (req_op)
                     OP_LOAD_TRACK: begin
                        if (tcount_ff < TC_W'(MAX_TRACKS)) begin
                           tcount_ff <= tcount_ff + 1'b1;
                        end
                     end
                     OP_LOAD_DET: begin
                        if (dcount_ff < DC_W'(MAX_DETECTIONS)) begin
                           dcount_ff <= dcount_ff + 1'b1;
                        end
                     end
                     OP_SOLVE: begin
                        nres_ff  <= '0;
                        pend_ff  <= 1'b0;
                        state_ff <= ST_ROUND;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_ROUND: begin
               issue_ff <= '0;
               state_ff <= ST_SWEEP;
            end
            ST_SWEEP: begin
               if (issue_go) begin
                  issue_ff <= issue_ff + 1'b1;
               end else if (!v1_ff && !v2_ff && !v3_ff) begin
                  red_ff   <= '0;
                  state_ff <= ST_REDUCE;
               end
            end
            ST_REDUCE: begin
               red_ff <= red_ff + 1'b1;
               if (red_ff == TI_W'(MAX_TRACKS-1)) begin
                  state_ff <= ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               if (win) begin
                  dtaken_ff[ch_d[MAX_TRACKS]] <= 1'b1;
                  // the held pair is not the final one: send it now
                  if (pend_ff) begin
                     rsp_valid_ff   <= 1'b1;
                     rsp_matched_ff <= 1'b1;
                     rsp_t_ff       <= IDX_OUT_W'(pend_t_ff);
                     rsp_d_ff       <= IDX_OUT_W'(pend_d_ff);
                     rsp_last_ff    <= 1'b0;
                  end
                  pend_ff   <= 1'b1;
                  pend_t_ff <= ch_t[MAX_TRACKS];
                  pend_d_ff <= ch_d[MAX_TRACKS];
                  nres_ff   <= nres_ff + 1'b1;
                  state_ff  <= (nres_ff == RC_W'(MAX_RESULTS-1)) ? ST_FINISH : ST_ROUND;
               end else begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               // held pair goes out marked last, or a lone unmatched word
               rsp_valid_ff   <= 1'b1;
               rsp_matched_ff <= pend_ff;
               rsp_t_ff       <= pend_ff ? IDX_OUT_W'(pend_t_ff) : '0;
               rsp_d_ff       <= pend_ff ? IDX_OUT_W'(pend_d_ff) : '0;
               rsp_last_ff    <= 1'b1;
               tcount_ff      <= '0;
               dcount_ff      <= '0;
               dtaken_ff      <= '0;
               pend_ff        <= 1'b0;
               state_ff       <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
      d1_ff <= issue_addr;
      d2_ff <= d1_ff;
      d3_ff <= d2_ff;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_matched         = rsp_matched_ff;
   assign rsp_track_index     = rsp_t_ff;
   assign rsp_detection_index = rsp_d_ff;
   assign rsp_last            = rsp_last_ff;

   a_last_ends_solve: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !busy) else $error("last word while busy");
   a_unmatched_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_matched |-> rsp_last) else $error("unmatched not last");
   a_track_cap: assert property (@(posedge clock) disable iff (reset)
      tcount_ff <= TC_W'(MAX_TRACKS)) else $error("track count overflow");
   a_pipe_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_REDUCE |-> !v3_ff) else $error("compare during reduce");
endmodule

// ===== sim/greedy_gated_nearest_assignment_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_gated_nearest_assignment_test: self-checking bench for the assigner
// Loads frames of track and detection points, solves them under several gate
// settings and checks every response word against an in-bench predictor.
// ----------------------------------------------------------------------------
module greedy_gated_nearest_assignment_test;
   import ggna_pkg::*;

   localparam int TRACK_CAP  = MAX_TRACKS_DEF;
   localparam int DET_CAP    = MAX_DETECTIONS_DEF;
   localparam int CYCLE_CAP  = 1500000;
   localparam int DRAIN_WAIT = 100;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic                 matched;
      logic [IDX_OUT_W-1:0] track_index;
      logic [IDX_OUT_W-1:0] detection_index;
      logic                 last;
   } pair_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_op = OP_LOAD_TRACK;
   logic signed [POS_W-1:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic rsp_valid, rsp_matched, rsp_last;
   logic [IDX_OUT_W-1:0] rsp_track_index, rsp_detection_index;
   logic csr_wr_en = 1'b0;
   logic [GATE_W-1:0] csr_wr_data = '0;

   greedy_gated_nearest_assignment u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_pos_x(req_pos_x), .req_pos_y(req_pos_y),
      .req_pos_z(req_pos_z), .rsp_valid(rsp_valid), .rsp_matched(rsp_matched),
      .rsp_track_index(rsp_track_index), .rsp_detection_index(rsp_detection_index),
      .rsp_last(rsp_last), .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // ---- predictor state: a private copy of the frame and the gate ----
   logic signed [POS_W-1:0] trk_pt [TRACK_CAP][3];
   logic signed [POS_W-1:0] det_pt [DET_CAP][3];
   int unsigned trk_cnt = 0, det_cnt = 0;
   logic [GATE_W-1:0] gate_sq = GATE_RESET;
   pair_word_type pending_pairs[$];

   int  errors = 0;
   int  cycles = 0;
   bit  no_idle = 1'b0;   // set during the stretch with no sender gaps

   // Exact squared distance; 3 * 65535^2 fits easily in 64 bits.
   function automatic logic [63:0] dist_sq(int t, int d);
      logic [63:0] acc;
      longint diff;
      acc = 0;
      for (int k = 0; k < 3; k++) begin
         diff = longint'(trk_pt[t][k]) - longint'(det_pt[d][k]);
         acc += 64'(diff * diff);
      end
      return acc;
   endfunction

   // Greedy solve: pick the closest free pair (scan order breaks ties toward
   // the low track, then the low detection) until the gate fails.
   task automatic predict_solve();
      logic [31:0] t_used, d_used;
      logic [63:0] best, dd;
      int bt, bd, n;
      bit found;
      pair_word_type w;
      t_used = '0; d_used = '0; n = 0;
      while (n < MAX_RESULTS) begin
         found = 1'b0; best = 0; bt = 0; bd = 0;
         for (int t = 0; t < trk_cnt; t++) begin
            if (t_used[t]) continue;
            for (int d = 0; d < det_cnt; d++) begin
               if (d_used[d]) continue;
               dd = dist_sq(t, d);
               if (!found || dd < best) begin
                  found = 1'b1; best = dd; bt = t; bd = d;
               end
            end
         end
         if (!found || best > {30'd0, gate_sq}) break;
         t_used[bt] = 1'b1;
         d_used[bd] = 1'b1;
         w = '{1'b1, bt[IDX_OUT_W-1:0], bd[IDX_OUT_W-1:0], 1'b0};
         pending_pairs = {pending_pairs, w};
         n++;
      end
      if (n == 0) begin
         w = '{1'b0, '0, '0, 1'b1};
         pending_pairs = {pending_pairs, w};
      end else begin
         pending_pairs[pending_pairs.size() - 1].last = 1'b1;
      end
      trk_cnt = 0;
      det_cnt = 0;
   endtask

   task automatic predict_word(logic [1:0] op, logic signed [POS_W-1:0] x,
                               logic signed [POS_W-1:0] y, logic signed [POS_W-1:0] z);
      case (op)
         OP_LOAD_TRACK: begin
            // beyond capacity the load is dropped
            if (trk_cnt < TRACK_CAP) begin
               trk_pt[trk_cnt][0] = x; trk_pt[trk_cnt][1] = y; trk_pt[trk_cnt][2] = z;
               trk_cnt++;
            end
         end
         OP_LOAD_DET: begin
            if (det_cnt < DET_CAP) begin
               det_pt[det_cnt][0] = x; det_pt[det_cnt][1] = y; det_pt[det_cnt][2] = z;
               det_cnt++;
            end
         end
         OP_SOLVE: predict_solve();
         default: ;   // unused opcode: no effect
      endcase
   endtask

   // ---- sender: one word per call, random gaps unless no_idle ----
   task automatic send_word(logic [1:0] op, logic signed [POS_W-1:0] x,
                            logic signed [POS_W-1:0] y, logic signed [POS_W-1:0] z);
      if (!no_idle && $urandom_range(99) < 25) begin
         @(negedge clock);
         start = 1'b0;
         repeat ($urandom_range(5)) @(negedge clock);
      end
      @(negedge clock);
      start = 1'b1;
      req_op = op; req_pos_x = x; req_pos_y = y; req_pos_z = z;
      // accepted at the first rising edge with busy low
      do @(posedge clock); while (busy);
      predict_word(op, x, y, z);
   endtask

   // Wait for every pending response, then let the block settle.
   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (pending_pairs.size() != 0 || busy) @(posedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic write_gate(logic [GATE_W-1:0] value);
      drain();
      csr_wr_en = 1'b1;
      csr_wr_data = value;
      gate_sq = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   function automatic logic signed [POS_W-1:0] near(logic signed [POS_W-1:0] c, int spread);
      int v;
      v = int'(c) + $urandom_range(2 * spread) - spread;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return POS_W'(v);
   endfunction

   // ---- response checker ----
   always @(posedge clock) begin
      pair_word_type exp_w;
      cycles <= cycles + 1;
      if (!reset && rsp_valid) begin
         if (pending_pairs.size() == 0) begin
            $error("response word with nothing expected");
            errors++;
         end else begin
            exp_w = pending_pairs.pop_front();
            if (rsp_matched !== exp_w.matched) begin
               $error("matched: expected %0d got %0d", exp_w.matched, rsp_matched);
               errors++;
            end
            if (rsp_track_index !== exp_w.track_index) begin
               $error("track_index: expected %0d got %0d", exp_w.track_index,
                      rsp_track_index);
               errors++;
            end
            if (rsp_detection_index !== exp_w.detection_index) begin
               $error("detection_index: expected %0d got %0d", exp_w.detection_index,
                      rsp_detection_index);
               errors++;
            end
            if (rsp_last !== exp_w.last) begin
               $error("last: expected %0d got %0d", exp_w.last, rsp_last);
               errors++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (cycles > CYCLE_CAP) begin
         $display("[greedy_gated_nearest_assignment] ERROR");
         $finish;
      end
   end

   // ---- tests ----
   task automatic test_basic_pairs();
      // default gate: two tracks, two close detections in swapped order
      send_word(OP_LOAD_TRACK, 16'sd0, 16'sd0, 16'sd0);
      send_word(OP_LOAD_TRACK, 16'sd5000, 16'sd5000, 16'sd0);
      send_word(OP_LOAD_DET, 16'sd5100, 16'sd4900, 16'sd10);
      send_word(OP_LOAD_DET, 16'sd30, -16'sd20, 16'sd0);
      send_word(OP_SOLVE, 16'sd0, 16'sd0, 16'sd0);
      // empty frame: one unmatched word
      send_word(OP_SOLVE, 16'sd0, 16'sd0, 16'sd0);
      // unused opcode does nothing, then only tracks: unmatched
      send_word(OP_UNUSED, -16'sd1, -16'sd1, -16'sd1);
      send_word(OP_LOAD_TRACK, 16'sd1, 16'sd2, 16'sd3);
      send_word(OP_SOLVE, 16'sd0, 16'sd0, 16'sd0);
   endtask

   task automatic test_ties();
      // equal tracks and equidistant detections: low indices win
      send_word(OP_LOAD_TRACK, 16'sd100, 16'sd100, 16'sd100);
      send_word(OP_LOAD_TRACK, 16'sd100, 16'sd100, 16'sd100);
      send_word(OP_LOAD_DET, 16'sd110, 16'sd100, 16'sd100);
      send_word(OP_LOAD_DET, 16'sd90, 16'sd100, 16'sd100);
      send_word(OP_SOLVE, 16'sd0, 16'sd0, 16'sd0);
   endtask

   task automatic test_gate_extremes();
      // widest gate: opposite corners still pair
      write_gate({GATE_W{1'b1}});
      send_word(OP_LOAD_TRACK, -16'sd32768, -16'sd32768, -16'sd32768);
      send_word(OP_LOAD_DET, 16'sd32767, 16'sd32767, 16'sd32767);
      send_word(OP_SOLVE, 16'sd0, 16'sd0, 16'sd0);
      // zero gate: only coincident points pair
      write_gate('0);
      send_word(OP_LOAD_TRACK, 16'sd32767, -16'sd32768, 16'sd7);
      send_word(OP_LOAD_TRACK, 16'sd0, 16'sd0, 16'sd0);
      send_word(OP_LOAD_DET, 16'sd0, 16'sd0, 16'sd1);
      send_word(OP_LOAD_DET, 16'sd32767, -16'sd32768, 16'sd7);
      send_word(OP_SOLVE, 16'sd0, 16'sd0, 16'sd0);
   endtask

   task automatic test_capacity();
      // one load past capacity on each side; a full 32-pair solve
      write_gate({GATE_W{1'b1}});
      for (int i = 0; i <= TRACK_CAP; i++)
         send_word(OP_LOAD_TRACK, POS_W'(i * 200), POS_W'(-i * 50), POS_W'(i));
      for (int i = 0; i <= DET_CAP; i++)
         send_word(OP_LOAD_DET, POS_W'((DET_CAP - i) * 200 + 3), POS_W'(-i * 40), 16'sd0);
      send_word(OP_SOLVE, 16'sd0, 16'sd0, 16'sd0);
   endtask

   task automatic test_random_frames(int word_goal);
      int sent, nt, nd;
      logic signed [POS_W-1:0] cx, cy, cz;
      logic [GATE_W-1:0] gates [4];
      gates[0] = GATE_RESET; gates[1] = 34'd250000;
      gates[2] = 34'd4000000; gates[3] = {GATE_W{1'b1}};
      sent = 0;
      while (sent < word_goal) begin
         if ($urandom_range(3) == 0) write_gate(gates[$urandom_range(3)]);
         // third quarter runs without sender gaps
         no_idle = (sent > word_goal / 2) && (sent < 3 * word_goal / 4);
         if ($urandom_range(9) == 0) begin
            // noise: full-range points, stray opcode
            send_word(OP_UNUSED, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom));
            send_word(OP_LOAD_TRACK, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom));
            send_word(OP_LOAD_DET, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom));
            send_word(OP_SOLVE, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom));
            sent += 4;
         end else begin
            // clustered frame so most pairs fall inside the gate
            nt = $urandom_range(5);
            nd = $urandom_range(5);
            cx = POS_W'($urandom_range(40000) - 20000);
            cy = POS_W'($urandom_range(40000) - 20000);
            cz = POS_W'($urandom_range(40000) - 20000);
            for (int i = 0; i < nt; i++)
               send_word(OP_LOAD_TRACK, near(cx, 900), near(cy, 900), near(cz, 900));
            for (int i = 0; i < nd; i++)
               send_word(OP_LOAD_DET, near(cx, 900), near(cy, 900), near(cz, 900));
            send_word(OP_SOLVE, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom));
            sent += nt + nd + 1;
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_basic_pairs();
      test_ties();
      test_gate_extremes();
      test_capacity();
      test_random_frames(120);
      drain();
      if (errors == 0) begin
         $display("[greedy_gated_nearest_assignment] OK");
      end else begin
         $display("[greedy_gated_nearest_assignment] ERROR");
      end
      $finish;
   end

endmodule
